@@ src/tksh_pkg.sv @@
// Package for the top-K score heap: widths, codes, command/status types, helpers.
`timescale 1ns / 1ps
`default_nettype none

package tksh_pkg;

   // Field widths fixed by the block's interface
   localparam int REQ_TYPE_W = 2;
   localparam int SCORE_W    = 32;
   localparam int PAYLOAD_W  = 64;
   localparam int SLOT_W     = 4;
   localparam int LIMIT_W    = 5;
   localparam int COUNT_W    = 5;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LIMIT_W;

   // Parameter defaults
   localparam int MAX_KEPT_DEFAULT  = 16;
   localparam int BODY_BITS_DEFAULT = 64;

   // Register reset values
   localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RESET   = LIMIT_W'(16);
   localparam logic               KEEP_HIGHEST_RESET = 1'b1;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_LIMIT   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_HIGHEST = 1'd1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // latch the request, clear the working result
      logic rd_root;    // read slot 0, start a sift-down at the root
      logic rd_parent;  // read the parent of the current position
      logic rd_kids;    // read both children of the current position
      logic rd_slot;    // read the slot that a read request names
      logic cap_slot;   // capture read data into the working result
      logic move_up;    // copy the parent down, step up
      logic move_dn;    // copy the chosen child up, step down
      logic place_up;   // write the new record, grow the heap
      logic place_dn;   // write the new record at the sift-down position
      logic clear;      // empty the heap
      logic load_rsp;   // move the working result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_add;
      logic is_read;
      logic is_clear;
      logic limit_zero;
      logic has_room;
      logic pos_zero;
      logic up_move;
      logic root_beaten;
      logic dn_move;
      logic rsp_free;
   } status_type;

   // True if a ranks strictly further from the root than b
   function automatic logic beats(input logic signed [SCORE_W-1:0] a,
                                  input logic signed [SCORE_W-1:0] b,
                                  input logic highest);
      return highest ? (a > b) : (a < b);
   endfunction

endpackage

`default_nettype wire

@@ src/tksh_if.sv @@
// Request and response channel interfaces of the top-K score heap.
`timescale 1ns / 1ps
`default_nettype none

interface tksh_req_if import tksh_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic [REQ_TYPE_W-1:0]       req_type;
   logic signed [SCORE_W-1:0]   score;
   logic [PAYLOAD_W-1:0]        payload;
   logic [SLOT_W-1:0]           slot_index;

   modport source (output valid, output req_type, output score, output payload,
                   output slot_index, input ready);
   modport sink   (input valid, input req_type, input score, input payload,
                   input slot_index, output ready);
endinterface

interface tksh_rsp_if import tksh_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic                        stored;
   logic [COUNT_W-1:0]          kept_count;
   logic                        read_valid;
   logic signed [SCORE_W-1:0]   read_score;
   logic [PAYLOAD_W-1:0]        read_payload;

   modport source (output valid, output stored, output kept_count, output read_valid,
                   output read_score, output read_payload, input ready);
   modport sink   (input valid, input stored, input kept_count, input read_valid,
                   input read_score, input read_payload, output ready);
endinterface

`default_nettype wire

@@ src/tksh_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module tksh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_a_addr,
   output      logic [WIDTH-1:0]  rd_a_data,
   input  wire logic [ADDR_W-1:0] rd_b_addr,
   output      logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

@@ src/tksh_ctrl.sv @@
// Controller state machine of the top-K score heap.
`timescale 1ns / 1ps
`default_nettype none

module tksh_ctrl import tksh_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   output      cmd_type    cmd,
   input  wire status_type status
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DECIDE   = 9'b000000010,
      S_UP_RD    = 9'b000000100,
      S_UP_CMP   = 9'b000001000,
      S_ROOT_CMP = 9'b000010000,
      S_DN_RD    = 9'b000100000,
      S_DN_CMP   = 9'b001000000,
      S_SLOT_CAP = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Sequence one request through the heap
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.is_add) begin
               if (status.limit_zero) begin
                  state_in = S_FINISH;
               end else if (status.has_room) begin
                  state_in = S_UP_RD;
               end else begin
                  cmd.rd_root = 1'b1;
                  state_in    = S_ROOT_CMP;
               end
            end else if (status.is_read) begin
               cmd.rd_slot = 1'b1;
               state_in    = S_SLOT_CAP;
            end else if (status.is_clear) begin
               cmd.clear = 1'b1;
               state_in  = S_FINISH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_UP_RD: begin
            if (status.pos_zero) begin
               cmd.place_up = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (status.up_move) begin
               cmd.move_up = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.place_up = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_ROOT_CMP: begin
            // drop a record that does not beat the root
            state_in = status.root_beaten ? S_DN_RD : S_FINISH;
         end
         S_DN_RD: begin
            cmd.rd_kids = 1'b1;
            state_in    = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (status.dn_move) begin
               cmd.move_dn = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               cmd.place_dn = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_SLOT_CAP: begin
            cmd.cap_slot = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register can take the result
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/tksh_dp.sv @@
// Datapath of the top-K score heap: heap RAM, sift position, count and result registers.
`timescale 1ns / 1ps
`default_nettype none

module tksh_dp import tksh_pkg::*; #(
   parameter int MAX_KEPT  = MAX_KEPT_DEFAULT,
   parameter int BODY_BITS = BODY_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration writes
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata,
   // request payload
   input  wire logic [REQ_TYPE_W-1:0]     req_type,
   input  wire logic signed [SCORE_W-1:0] req_score,
   input  wire logic [PAYLOAD_W-1:0]      req_payload,
   input  wire logic [SLOT_W-1:0]         req_slot_index,
   // response register
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic                      rsp_stored,
   output      logic [COUNT_W-1:0]        rsp_kept_count,
   output      logic                      rsp_read_valid,
   output      logic signed [SCORE_W-1:0] rsp_read_score,
   output      logic [PAYLOAD_W-1:0]      rsp_read_payload,
   // controller link
   input  wire cmd_type                   cmd,
   output      status_type                status
);

   localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW     = $clog2(MAX_KEPT + 1);
   localparam int KW     = AW + 2;
   localparam int LW     = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int IW     = ((CW > SLOT_W) ? CW : SLOT_W) + 1;
   localparam int WORD_W = SCORE_W + BODY_BITS;

   // Limit as it acts, clamped to the heap capacity
   function automatic logic [CW-1:0] eff_limit(input logic [LIMIT_W-1:0] v);
      if (LW'(v) > LW'(MAX_KEPT)) begin
         return CW'(MAX_KEPT);
      end
      return CW'(v);
   endfunction

   // Configuration and heap occupancy
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic                     highest_ff, highest_in;
   logic [CW-1:0]            count_ff, count_in;

   // Latched request
   logic [REQ_TYPE_W-1:0]    kind_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic [BODY_BITS-1:0]     body_ff;
   logic [SLOT_W-1:0]        idx_ff;
   logic [AW-1:0]            pos_ff, pos_in;

   // Working result
   logic                     stored_ff;
   logic                     rvalid_ff;
   logic signed [SCORE_W-1:0] rscore_ff;
   logic [BODY_BITS-1:0]     rbody_ff;

   // Output register
   logic                     out_valid_ff;
   logic                     out_stored_ff;
   logic [COUNT_W-1:0]       out_count_ff;
   logic                     out_rvalid_ff;
   logic signed [SCORE_W-1:0] out_rscore_ff;
   logic [PAYLOAD_W-1:0]     out_rbody_ff;

   // RAM ports
   logic                     wr_en;
   logic [AW-1:0]            rd_a_addr;
   logic [AW-1:0]            rd_b_addr;
   logic [WORD_W-1:0]        wr_data;
   logic [WORD_W-1:0]        rd_a_data;
   logic [WORD_W-1:0]        rd_b_data;

   // Heap arithmetic
   logic [CW-1:0]            limit_eff;
   logic [CW-1:0]            new_limit;
   logic [AW-1:0]            up_pos;
   logic [KW-1:0]            kid_a;
   logic [KW-1:0]            kid_b;
   logic                     has_a;
   logic                     has_b;
   logic signed [SCORE_W-1:0] score_a;
   logic signed [SCORE_W-1:0] score_b;
   logic                     beat_a;
   logic                     beat_b;
   logic                     pick_b;
   logic                     slot_ok;

   assign limit_eff = eff_limit(limit_ff);
   assign new_limit = eff_limit(csr_wdata);

   assign score_a = rd_a_data[WORD_W-1 -: SCORE_W];
   assign score_b = rd_b_data[WORD_W-1 -: SCORE_W];

   assign up_pos = (pos_ff - AW'(1)) >> 1;
   assign kid_a  = KW'({pos_ff, 1'b1});
   assign kid_b  = kid_a + KW'(1);
   assign has_a  = kid_a < KW'(count_ff);
   assign has_b  = kid_b < KW'(count_ff);

   // Pick the child to promote during a sift-down
   assign beat_a = has_a && beats(score_ff, score_a, highest_ff);
   assign beat_b = has_b && beats(score_ff, score_b, highest_ff);
   assign pick_b = beat_a ? (beat_b && beats(score_a, score_b, highest_ff)) : beat_b;

   assign slot_ok = (IW'(idx_ff) < IW'(count_ff)) && (IW'(idx_ff) < IW'(MAX_KEPT));

   // Status to the controller
   always_comb begin
      status.is_add      = (kind_ff == REQ_ADD);
      status.is_read     = (kind_ff == REQ_READ);
      status.is_clear    = (kind_ff == REQ_CLEAR);
      status.limit_zero  = (limit_eff == '0);
      status.has_room    = (count_ff < limit_eff);
      status.pos_zero    = (pos_ff == '0);
      status.up_move     = beats(score_a, score_ff, highest_ff);
      status.root_beaten = beats(score_ff, score_a, highest_ff);
      status.dn_move     = beat_a || beat_b;
      status.rsp_free    = !out_valid_ff || rsp_ready;
   end

   // Select RAM read addresses
   always_comb begin
      rd_a_addr = '0;
      if (cmd.rd_parent) begin
         rd_a_addr = up_pos;
      end else if (cmd.rd_kids) begin
         rd_a_addr = kid_a[AW-1:0];
      end else if (cmd.rd_slot) begin
         rd_a_addr = AW'(idx_ff);
      end
      rd_b_addr = kid_b[AW-1:0];
   end

   // Select RAM write data
   always_comb begin
      wr_en = cmd.move_up || cmd.move_dn || cmd.place_up || cmd.place_dn;
      if (cmd.move_up) begin
         wr_data = rd_a_data;
      end else if (cmd.move_dn) begin
         wr_data = pick_b ? rd_b_data : rd_a_data;
      end else begin
         wr_data = {score_ff, body_ff};
      end
   end

   tksh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_KEPT)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (pos_ff),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   // Advance the sift position
   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept) begin
         pos_in = AW'(count_ff);
      end else if (cmd.rd_root) begin
         pos_in = '0;
      end else if (cmd.move_up) begin
         pos_in = up_pos;
      end else if (cmd.move_dn) begin
         pos_in = pick_b ? kid_b[AW-1:0] : kid_a[AW-1:0];
      end
   end

   // Update configuration and occupancy; a lower limit trims the heap
   always_comb begin
      limit_in   = limit_ff;
      highest_in = highest_ff;
      count_in   = count_ff;
      if (csr_wr_en && (csr_index == CSR_KEEP_LIMIT)) begin
         limit_in = csr_wdata;
         if (count_ff > new_limit) begin
            count_in = new_limit;
         end
      end else if (csr_wr_en && (csr_index == CSR_KEEP_HIGHEST)) begin
         highest_in = csr_wdata[0];
      end else if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.place_up) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= KEEP_LIMIT_RESET;
         highest_ff <= KEEP_HIGHEST_RESET;
         count_ff   <= '0;
      end else begin
         limit_ff   <= limit_in;
         highest_ff <= highest_in;
         count_ff   <= count_in;
      end
   end

   // Latch the request and build the working result
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.accept) begin
         kind_ff   <= req_type;
         score_ff  <= req_score;
         body_ff   <= req_payload[BODY_BITS-1:0];
         idx_ff    <= req_slot_index;
         stored_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         rscore_ff <= '0;
         rbody_ff  <= '0;
      end
      if (cmd.place_up || cmd.place_dn) begin
         stored_ff <= 1'b1;
      end
      if (cmd.cap_slot && slot_ok) begin
         rvalid_ff <= 1'b1;
         rscore_ff <= score_a;
         rbody_ff  <= rd_a_data[BODY_BITS-1:0];
      end
   end

   // Output register: load a result, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_stored_ff <= stored_ff;
         out_count_ff  <= COUNT_W'(count_ff);
         out_rvalid_ff <= rvalid_ff;
         out_rscore_ff <= rscore_ff;
         out_rbody_ff  <= PAYLOAD_W'(rbody_ff);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_stored       = out_stored_ff;
   assign rsp_kept_count   = out_count_ff;
   assign rsp_read_valid   = out_rvalid_ff;
   assign rsp_read_score   = out_rscore_ff;
   assign rsp_read_payload = out_rbody_ff;

endmodule

`default_nettype wire

@@ src/top_k_score_heap.sv @@
// Top level of the top-K score heap: controller, datapath and channel hookup.
//
//   channel   direction  transfer moves
//   req_chan  in         req_type, score, payload, slot_index
//   rsp_chan  out        stored, kept_count, read_valid, read_score, read_payload
//   csr_*     in         keep_limit (index 0), keep_highest (index 1)
//
// One request at a time; the next transfer can be taken in the cycle after the result loads.
// A clear, an unknown request and an add under a zero limit go straight to the result; a read
// reads and captures its slot; a filling add moves parents down until it stops or reaches the
// root; an add into a full heap is dropped unless it beats the root, else it sifts down by levels.
// Reset clears the count, the limit to 16 and the order to highest; heap slots are not cleared.
// A result waits in the output register; the next one holds in the controller until it frees.
`timescale 1ns / 1ps
`default_nettype none

module top_k_score_heap import tksh_pkg::*; #(
   parameter int MAX_KEPT  = MAX_KEPT_DEFAULT,
   parameter int BODY_BITS = BODY_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tksh_req_if.sink                    req_chan,
   tksh_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_chan.ready = req_ready;

   tksh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   tksh_dp #(
      .MAX_KEPT  (MAX_KEPT),
      .BODY_BITS (BODY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_type         (req_chan.req_type),
      .req_score        (req_chan.score),
      .req_payload      (req_chan.payload),
      .req_slot_index   (req_chan.slot_index),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_stored       (rsp_chan.stored),
      .rsp_kept_count   (rsp_chan.kept_count),
      .rsp_read_valid   (rsp_chan.read_valid),
      .rsp_read_score   (rsp_chan.read_score),
      .rsp_read_payload (rsp_chan.read_payload),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

@@ verif/top_k_score_heap_checker.sv @@
// Reply checker for the top-K score heap: tracks the heap, predicts each reply, compares.
`timescale 1ns / 1ps

module top_k_score_heap_checker import tksh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   tksh_req_if                    req_mon,
   tksh_rsp_if                    rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     replies_pending
);

   localparam int unsigned CAPACITY = MAX_KEPT_DEFAULT;

   typedef struct {
      logic                      stored;
      logic [COUNT_W-1:0]        kept_count;
      logic                      read_valid;
      logic signed [SCORE_W-1:0] read_score;
      logic [PAYLOAD_W-1:0]      read_payload;
   } heap_reply_type;

   // Shadow copy of the heap and its settings
   logic signed [SCORE_W-1:0] heap_score [CAPACITY];
   logic [PAYLOAD_W-1:0]      heap_body  [CAPACITY];
   int unsigned               held;
   logic [LIMIT_W-1:0]        keep_limit;
   logic                      keep_highest;

   heap_reply_type            replies_due [$];
   heap_reply_type            want;

   // True if a sits further from the root than b under the current order
   function automatic bit outranks(input logic signed [SCORE_W-1:0] a,
                                   input logic signed [SCORE_W-1:0] b);
      if (keep_highest) begin
         return a > b;
      end
      return a < b;
   endfunction

   function automatic int unsigned effective_limit();
      return (keep_limit > CAPACITY) ? CAPACITY : int'(keep_limit);
   endfunction

   // Move a new record from the bottom toward the root
   function automatic void float_up(input int unsigned pos,
                                    input logic signed [SCORE_W-1:0] s,
                                    input logic [PAYLOAD_W-1:0] body);
      int unsigned parent;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (!outranks(heap_score[parent], s)) break;
         heap_score[pos] = heap_score[parent];
         heap_body[pos]  = heap_body[parent];
         pos = parent;
      end
      heap_score[pos] = s;
      heap_body[pos]  = body;
   endfunction

   // Replace the root and push the new record down to its level
   function automatic void sink_root(input int unsigned count,
                                     input logic signed [SCORE_W-1:0] s,
                                     input logic [PAYLOAD_W-1:0] body);
      int unsigned pos, lc, rc, nxt;
      bit          go;
      pos = 0;
      go  = 1'b1;
      while (go) begin
         lc = 2 * pos + 1;
         rc = lc + 1;
         if (lc < count && outranks(s, heap_score[lc])) begin
            if (rc < count && outranks(s, heap_score[rc]) &&
                outranks(heap_score[lc], heap_score[rc])) begin
               nxt = rc;
            end else begin
               nxt = lc;
            end
         end else if (rc < count && outranks(s, heap_score[rc])) begin
            nxt = rc;
         end else begin
            go = 1'b0;
         end
         if (go) begin
            heap_score[pos] = heap_score[nxt];
            heap_body[pos]  = heap_body[nxt];
            pos = nxt;
         end
      end
      heap_score[pos] = s;
      heap_body[pos]  = body;
   endfunction

   // Apply one request to the shadow heap and return the reply it should give
   function automatic heap_reply_type predict_reply(input logic [REQ_TYPE_W-1:0] kind,
                                                    input logic signed [SCORE_W-1:0] s,
                                                    input logic [PAYLOAD_W-1:0] body,
                                                    input logic [SLOT_W-1:0] slot);
      heap_reply_type r;
      int unsigned    lim;
      r   = '{stored: 1'b0, kept_count: '0, read_valid: 1'b0, read_score: '0,
              read_payload: '0};
      lim = effective_limit();
      if (held > lim) held = lim;
      case (kind)
         REQ_ADD: begin
            if (lim != 0) begin
               if (held < lim) begin
                  float_up(held, s, body);
                  held++;
                  r.stored = 1'b1;
               end else if (outranks(s, heap_score[0])) begin
                  sink_root(lim, s, body);
                  r.stored = 1'b1;
               end
            end
         end
         REQ_READ: begin
            if (slot < held) begin
               r.read_valid   = 1'b1;
               r.read_score   = heap_score[slot];
               r.read_payload = heap_body[slot];
            end
         end
         REQ_CLEAR: held = 0;
         default: ;
      endcase
      r.kept_count = COUNT_W'(held);
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, expected, actual);
         mismatches++;
      end
   endfunction

   // Track settings, match each reply transfer, queue a prediction per request transfer
   always @(posedge clock) begin
      if (reset) begin
         held         = 0;
         keep_limit   = KEEP_LIMIT_RESET;
         keep_highest = KEEP_HIGHEST_RESET;
         replies_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_KEEP_LIMIT) begin
               keep_limit = csr_wdata[LIMIT_W-1:0];
               if (held > effective_limit()) held = effective_limit();
            end else if (csr_index == CSR_KEEP_HIGHEST) begin
               keep_highest = csr_wdata[0];
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (replies_due.size() == 0) begin
               $error("reply transfer with no request outstanding");
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("stored", 64'(want.stored), 64'(rsp_mon.stored));
               check_field("kept_count", 64'(want.kept_count), 64'(rsp_mon.kept_count));
               check_field("read_valid", 64'(want.read_valid), 64'(rsp_mon.read_valid));
               check_field("read_score", 64'($unsigned(want.read_score)),
                           64'($unsigned(rsp_mon.read_score)));
               check_field("read_payload", want.read_payload, rsp_mon.read_payload);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            replies_due.push_back(predict_reply(req_mon.req_type, req_mon.score,
                                                req_mon.payload, req_mon.slot_index));
         end
      end
      replies_pending = replies_due.size();
   end

endmodule

@@ verif/top_k_score_heap_test.sv @@
// Test top for the top-K score heap: clock, reset, request traffic, reply stalls, verdict.
`timescale 1ns / 1ps

module top_k_score_heap_test;
   import tksh_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int PHASES          = 16;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int PRESSURE_PHASE  = 5;
   localparam int LONG_HOLD       = 300;
   localparam int QUIET_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 30;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     mismatches;
   int                     replies_pending;
   int                     quiet_cycles = 0;
   bit                     hold_off_now = 1'b0;

   tksh_req_if req_chan ();
   tksh_rsp_if rsp_chan ();

   top_k_score_heap u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   top_k_score_heap_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .replies_pending (replies_pending)
   );

   always #5 clock = ~clock;

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $error("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reply side: stall on a changing pattern, with one long hold-off on request
   initial begin
      int stall_mode;
      int mode_left;
      int hold_left;
      bit take;
      rsp_chan.ready = 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_off_now) begin
            hold_off_now = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            case (stall_mode)
               0: take = 1'b1;
               1: take = $urandom_range(0, 1);
               2: take = ($urandom_range(0, 4) == 0);
               default: take = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_chan.ready <= take;
      end
   end

   // Present one request and hold it until the transfer
   task automatic offer(input logic [REQ_TYPE_W-1:0] kind, input logic signed [SCORE_W-1:0] s,
                        input logic [PAYLOAD_W-1:0] body, input logic [SLOT_W-1:0] slot);
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.score      <= s;
      req_chan.payload    <= body;
      req_chan.slot_index <= slot;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding reply
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (replies_pending != 0);
   endtask

   // Write the limit and/or the order while the block is idle
   task automatic set_config(input bit do_limit, input logic [LIMIT_W-1:0] limit,
                             input bit do_order, input logic order);
      if (do_limit) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_KEEP_LIMIT;
         csr_wdata <= CSR_DATA_W'(limit);
         @(negedge clock);
      end
      if (do_order) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_KEEP_HIGHEST;
         csr_wdata <= {(CSR_DATA_W-1)'($urandom), order};
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [PAYLOAD_W-1:0] pick_body();
      return {$urandom, $urandom};
   endfunction

   // Mix extremes, a narrow band that forces ties, and full-range scores
   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1, 2, 3: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic [REQ_TYPE_W-1:0] pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 62) return REQ_ADD;
      if (roll < 90) return REQ_READ;
      if (roll < 96) return REQ_UNUSED;
      return REQ_CLEAR;
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return LIMIT_W'(1);
         2: return LIMIT_W'(16);
         3: return LIMIT_W'($urandom_range(17, 31));
         default: return LIMIT_W'($urandom_range(2, 15));
      endcase
   endfunction

   initial begin
      int  burst_left;
      bit  steady;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_ADD;
      req_chan.score      = '0;
      req_chan.payload    = '0;
      req_chan.slot_index = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Small heap keeping the highest: extremes, tie with the root, a replacement
      set_config(1'b1, LIMIT_W'(4), 1'b1, 1'b1);
      offer(REQ_ADD, 32'sh7FFF_FFFF, '1, '0);
      offer(REQ_ADD, 32'sh8000_0000, '0, '1);
      offer(REQ_ADD, 32'sh0000_0000, pick_body(), '0);
      offer(REQ_ADD, -32'sd1, pick_body(), '0);
      offer(REQ_ADD, 32'sh8000_0000, pick_body(), '0);
      offer(REQ_ADD, 32'sd5, pick_body(), '0);
      // Read held slots and slots beyond the count
      offer(REQ_READ, $signed($urandom), pick_body(), SLOT_W'(0));
      offer(REQ_READ, $signed($urandom), pick_body(), SLOT_W'(3));
      offer(REQ_READ, $signed($urandom), pick_body(), SLOT_W'(4));
      offer(REQ_READ, $signed($urandom), pick_body(), SLOT_W'(15));
      offer(REQ_UNUSED, $signed($urandom), pick_body(), '1);
      offer(REQ_CLEAR, $signed($urandom), pick_body(), '0);
      // Limit of zero stores nothing
      drain();
      set_config(1'b1, '0, 1'b1, 1'b0);
      offer(REQ_ADD, 32'sd1, pick_body(), '0);
      // Limit above capacity, keeping the lowest
      drain();
      set_config(1'b1, LIMIT_W'(31), 1'b0, 1'b0);
      offer(REQ_ADD, 32'sd100, pick_body(), '0);
      offer(REQ_ADD, -32'sd100, pick_body(), '0);
      offer(REQ_ADD, 32'sd7, pick_body(), '0);
      // Lower the limit below the held count
      drain();
      set_config(1'b1, LIMIT_W'(1), 1'b0, 1'b0);
      offer(REQ_READ, '0, pick_body(), SLOT_W'(0));
      offer(REQ_READ, '0, pick_body(), SLOT_W'(1));

      // Random phases, each under its own setting
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: set_config(1'b1, LIMIT_W'(16), 1'b1, 1'b1);
            1: set_config(1'b1, '0, 1'b1, 1'b0);
            2: set_config(1'b1, LIMIT_W'(31), 1'b1, 1'b1);
            3: set_config(1'b1, LIMIT_W'(1), 1'b1, 1'b0);
            default: set_config($urandom_range(0, 4) != 0, pick_limit(),
                                $urandom_range(0, 2) != 0, $urandom_range(0, 1));
         endcase
         steady = (phase % 4 == 2) || (phase == PRESSURE_PHASE);
         // Hold off the reply side while requests keep coming
         if (phase == PRESSURE_PHASE) hold_off_now = 1'b1;
         burst_left = $urandom_range(1, 16);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            offer(pick_kind(), pick_score(), pick_body(), SLOT_W'($urandom_range(0, 15)));
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if (!steady) idle_for($urandom_range(1, 12));
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && replies_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/tksh_pkg.sv
src/tksh_if.sv
src/tksh_ram.sv
src/tksh_ctrl.sv
src/tksh_dp.sv
src/top_k_score_heap.sv
verif/top_k_score_heap_checker.sv
verif/top_k_score_heap_test.sv
